@@ rtl/tcf_pkg.sv @@
// shared constants, types and helpers for the two-class oldest-first fifo
package tcf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_WIDTH   = 16;
	localparam int STAMP_WIDTH = 8;

	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = TAG_WIDTH + STAMP_WIDTH;

	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	// request opcodes
	localparam logic [1:0] OP_ENQ     = 2'd0;
	localparam logic [1:0] OP_DEQ0    = 2'd1;
	localparam logic [1:0] OP_DEQ1    = 2'd2;
	localparam logic [1:0] OP_DEQ_OLD = 2'd3;

	// result status codes
	localparam logic [2:0] STATUS_ENQUEUED = 3'd0;
	localparam logic [2:0] STATUS_DEQUEUED = 3'd1;
	localparam logic [2:0] STATUS_EMPTY    = 3'd2;
	localparam logic [2:0] STATUS_FULL     = 3'd3;
	localparam logic [2:0] STATUS_REJECTED = 3'd4;

	typedef logic [2:0] kind_t;

	// decoded command kinds handed from front to back
	localparam kind_t K_ENQ0    = 3'd0;
	localparam kind_t K_ENQ1    = 3'd1;
	localparam kind_t K_REJ     = 3'd2;
	localparam kind_t K_DEQ0    = 3'd3;
	localparam kind_t K_DEQ1    = 3'd4;
	localparam kind_t K_DEQ_OLD = 3'd5;

	typedef struct packed {
		kind_t                  kind;
		logic [TAG_WIDTH-1:0]   tag;
		logic [STAMP_WIDTH-1:0] stamp;
	} cmd_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

@@ rtl/tcf_ram.sv @@
// generic single-write, single-read ram with registered read data
module tcf_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/tcf_front.sv @@
// request intake: classifies requests, stamps enqueues, buffers commands
module tcf_front import tcf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [1:0]           item_class,
	input  logic [TAG_WIDTH-1:0] item_tag,
	output logic                 cmd_valid,
	output cmd_t                 cmd,
	input  logic                 cmd_pop
);

	cmd_t                   fifo_q [2];
	logic                   wr_q;
	logic                   rd_q;
	logic [1:0]             fill_q;
	logic [STAMP_WIDTH-1:0] stamp_q;
	cmd_t                   new_cmd;
	logic                   push;
	logic                   is_enq;

	assign in_ready  = (fill_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign is_enq    = (opcode == OP_ENQ);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_comb begin
		new_cmd.tag   = item_tag;
		new_cmd.stamp = stamp_q;
		case (opcode)
			OP_ENQ: begin
				// classes 2 and 3 are rejected but still take a stamp
				if (item_class[1]) begin
					new_cmd.kind = K_REJ;
				end else if (item_class[0]) begin
					new_cmd.kind = K_ENQ1;
				end else begin
					new_cmd.kind = K_ENQ0;
				end
			end
			OP_DEQ0:    new_cmd.kind = K_DEQ0;
			OP_DEQ1:    new_cmd.kind = K_DEQ1;
			default:    new_cmd.kind = K_DEQ_OLD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			fill_q  <= 2'd0;
			stamp_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			case ({push, cmd_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
			if (push && is_enq) begin
				stamp_q <= stamp_q + STAMP_WIDTH'(1);
			end
		end
	end

endmodule

@@ rtl/tcf_back.sv @@
// ring storage and command execution with the result register
module tcf_back import tcf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	input  cmd_t                   cmd,
	output logic                   cmd_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	output logic                   out_class,
	output logic [TAG_WIDTH-1:0]   out_tag,
	output logic [STAMP_WIDTH-1:0] out_stamp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic                   state_q;
	kind_t                  kind_q;
	logic [PTR_W-1:0]       head0_q, tail0_q, head1_q, tail1_q;
	logic [CNT_W-1:0]       cnt0_q, cnt1_q;
	logic                   out_valid_q;
	logic [2:0]             status_q;
	logic                   class_q;
	logic [TAG_WIDTH-1:0]   tag_q;
	logic [STAMP_WIDTH-1:0] stamp_q;

	logic                   out_free;
	logic                   we0, we1, re;
	logic [ENTRY_W-1:0]     wdata;
	logic [ENTRY_W-1:0]     rdata0, rdata1;
	logic [STAMP_WIDTH-1:0] stamp0, stamp1, diff;
	logic                   pick0, sel, sel_empty;
	logic                   full0, full1;
	logic                   is_deq;
	logic                   load_enq, finish_deq;

	tcf_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_ram0 (
		.clk   (clk),
		.we    (we0),
		.waddr (tail0_q),
		.wdata (wdata),
		.re    (re),
		.raddr (head0_q),
		.rdata (rdata0)
	);

	tcf_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH), .ADDR_W(PTR_W)) u_ram1 (
		.clk   (clk),
		.we    (we1),
		.waddr (tail1_q),
		.wdata (wdata),
		.re    (re),
		.raddr (head1_q),
		.rdata (rdata1)
	);

	assign out_free = !out_valid_q || out_ready;
	assign is_deq   = (cmd.kind == K_DEQ0) || (cmd.kind == K_DEQ1) ||
		(cmd.kind == K_DEQ_OLD);
	assign full0    = (cnt0_q == FULL_CNT);
	assign full1    = (cnt1_q == FULL_CNT);

	// enqueues finish at once; dequeues first read both ring heads
	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid && (is_deq || out_free);
	assign load_enq   = cmd_pop && !is_deq;
	assign re         = cmd_pop && is_deq;
	assign finish_deq = (state_q == S_READ) && out_free;
	assign wdata      = {cmd.tag, cmd.stamp};
	assign we0        = load_enq && (cmd.kind == K_ENQ0) && !full0;
	assign we1        = load_enq && (cmd.kind == K_ENQ1) && !full1;

	// wraparound age compare, ties and half-range distance go to class 1
	assign stamp0 = rdata0[STAMP_WIDTH-1:0];
	assign stamp1 = rdata1[STAMP_WIDTH-1:0];
	assign diff   = stamp1 - stamp0;
	assign pick0  = (diff != '0) && !diff[STAMP_WIDTH-1];

	always_comb begin
		case (kind_q)
			K_DEQ0: sel = 1'b0;
			K_DEQ1: sel = 1'b1;
			default: begin
				if (cnt0_q != '0 && cnt1_q != '0) begin
					sel = !pick0;
				end else begin
					sel = (cnt0_q == '0);
				end
			end
		endcase
		sel_empty = sel ? (cnt1_q == '0) : (cnt0_q == '0);
	end

	always_ff @(posedge clk) begin
		if (load_enq) begin
			class_q <= 1'b0;
			tag_q   <= '0;
			stamp_q <= cmd.stamp;
			case (cmd.kind)
				K_ENQ0:  status_q <= full0 ? STATUS_FULL : STATUS_ENQUEUED;
				K_ENQ1:  status_q <= full1 ? STATUS_FULL : STATUS_ENQUEUED;
				default: status_q <= STATUS_REJECTED;
			endcase
		end else if (finish_deq) begin
			if (sel_empty) begin
				status_q <= STATUS_EMPTY;
				class_q  <= 1'b0;
				tag_q    <= '0;
				stamp_q  <= '0;
			end else begin
				status_q <= STATUS_DEQUEUED;
				class_q  <= sel;
				tag_q    <= sel ? rdata1[ENTRY_W-1:STAMP_WIDTH] : rdata0[ENTRY_W-1:STAMP_WIDTH];
				stamp_q  <= sel ? stamp1 : stamp0;
			end
		end
		if (re) begin
			kind_q <= cmd.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			head0_q     <= '0;
			tail0_q     <= '0;
			cnt0_q      <= '0;
			head1_q     <= '0;
			tail1_q     <= '0;
			cnt1_q      <= '0;
		end else begin
			if (load_enq || finish_deq) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (re) begin
				state_q <= S_READ;
			end else if (finish_deq) begin
				state_q <= S_IDLE;
			end
			if (we0) begin
				tail0_q <= ptr_next(tail0_q);
				cnt0_q  <= cnt0_q + CNT_W'(1);
			end
			if (we1) begin
				tail1_q <= ptr_next(tail1_q);
				cnt1_q  <= cnt1_q + CNT_W'(1);
			end
			if (finish_deq && !sel_empty) begin
				if (sel) begin
					head1_q <= ptr_next(head1_q);
					cnt1_q  <= cnt1_q - CNT_W'(1);
				end else begin
					head0_q <= ptr_next(head0_q);
					cnt0_q  <= cnt0_q - CNT_W'(1);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_class = class_q;
	assign out_tag   = tag_q;
	assign out_stamp = stamp_q;

endmodule

@@ rtl/two_class_fifo_oldest_first.sv @@
// top level of the two-class fifo with oldest-first dequeue
//
//  channel   handshake             payload
//  request   in_valid / in_ready   opcode, item_class, item_tag
//  result    out_valid / out_ready status, out_class, out_tag, out_stamp
//
// enqueue and rejected requests finish straight from idle, while dequeues
// go through a read state because the ring heads come from rams with registered read ports.
// a two-entry command queue sits between intake and execution, and the
// result register lets a new request in while a result waits for transfer.
// reset clears pointers, counts and the stamp counter; ring rams are not cleared.
module two_class_fifo_oldest_first import tcf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             opcode,
	input  logic [1:0]             item_class,
	input  logic [TAG_WIDTH-1:0]   item_tag,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	output logic                   out_class,
	output logic [TAG_WIDTH-1:0]   out_tag,
	output logic [STAMP_WIDTH-1:0] out_stamp
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	tcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.item_class (item_class),
		.item_tag   (item_tag),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	tcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_class (out_class),
		.out_tag   (out_tag),
		.out_stamp (out_stamp)
	);

endmodule

@@ tb/tb_two_class_fifo_oldest_first.sv @@
// testbench for the two-class oldest-first fifo: request driver, result checker, predictor
module tb_two_class_fifo_oldest_first import tcf_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int           REQUEST_TARGET = 1950;
	localparam logic [1:0]   CLS_ZERO       = 2'd0;
	localparam logic [1:0]   CLS_ONE        = 2'd1;
	localparam int           CALM_TAIL      = 200;
	localparam int           MAX_PRINTS     = 40;

	typedef struct {
		logic [1:0]           op;
		logic [1:0]           cls;
		logic [TAG_WIDTH-1:0] tag;
		bit                   hold;
	} request_t;

	typedef struct packed {
		logic [2:0]             status;
		logic                   cls;
		logic [TAG_WIDTH-1:0]   tag;
		logic [STAMP_WIDTH-1:0] stamp;
	} result_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             opcode = '0;
	logic [1:0]             item_class = '0;
	logic [TAG_WIDTH-1:0]   item_tag = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [2:0]             status;
	logic                   out_class;
	logic [TAG_WIDTH-1:0]   out_tag;
	logic [STAMP_WIDTH-1:0] out_stamp;

	two_class_fifo_oldest_first u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.item_class (item_class),
		.item_tag   (item_tag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_class  (out_class),
		.out_tag    (out_tag),
		.out_stamp  (out_stamp)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// predicted ring contents and stamp counter
	logic [TAG_WIDTH-1:0]   ring_tag [2][QUEUE_DEPTH];
	logic [STAMP_WIDTH-1:0] ring_stamp [2][QUEUE_DEPTH];
	int                     ring_head [2] = '{0, 0};
	int                     ring_tail [2] = '{0, 0};
	int                     ring_fill [2] = '{0, 0};
	logic [STAMP_WIDTH-1:0] stamp_ctr = '0;

	request_t requests_todo[$];
	result_t  results_due[$];
	int       requests_queued = 0;
	int       results_seen = 0;
	int       mismatches = 0;
	bit       req_done = 1'b0;
	bit       sending = 1'b0;
	bit       idle_on = 1'b1;
	int       send_gap = 0;
	int       sink_stall = 0;
	result_t  head_result;

	task automatic log_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at %0t, result %0d: %s", $realtime, results_seen, msg);
		mismatches++;
	endtask

	function automatic result_t pop_ring(input int c);
		result_t r;
		r = '0;
		if (ring_fill[c] == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			r.status = STATUS_DEQUEUED;
			r.cls    = c[0];
			r.tag    = ring_tag[c][ring_head[c]];
			r.stamp  = ring_stamp[c][ring_head[c]];
			ring_head[c] = (ring_head[c] == QUEUE_DEPTH - 1) ? 0 : ring_head[c] + 1;
			ring_fill[c]--;
		end
		return r;
	endfunction

	function automatic result_t predict_result(input logic [1:0] op, input logic [1:0] cls,
			input logic [TAG_WIDTH-1:0] tag);
		result_t                r;
		logic [STAMP_WIDTH-1:0] age_gap;
		int                     c;
		r = '0;
		case (op)
			OP_ENQ: begin
				// the stamp is consumed even when the item goes nowhere
				r.stamp   = stamp_ctr;
				stamp_ctr = stamp_ctr + STAMP_WIDTH'(1);
				c = int'(cls[0]);
				if (cls > CLS_ONE) begin
					r.status = STATUS_REJECTED;
				end else if (ring_fill[c] == QUEUE_DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					ring_tag[c][ring_tail[c]]   = tag;
					ring_stamp[c][ring_tail[c]] = r.stamp;
					ring_tail[c] = (ring_tail[c] == QUEUE_DEPTH - 1) ? 0 : ring_tail[c] + 1;
					ring_fill[c]++;
					r.status = STATUS_ENQUEUED;
				end
			end
			OP_DEQ0: r = pop_ring(0);
			OP_DEQ1: r = pop_ring(1);
			default: begin
				if (ring_fill[0] != 0 && ring_fill[1] != 0) begin
					// modular age: class 0 wins only when strictly older by less than half range
					age_gap = ring_stamp[1][ring_head[1]] - ring_stamp[0][ring_head[0]];
					c = (age_gap != '0 && age_gap < (STAMP_WIDTH'(1) << (STAMP_WIDTH - 1))) ?
						0 : 1;
				end else begin
					c = (ring_fill[0] != 0) ? 0 : 1;
				end
				r = pop_ring(c);
			end
		endcase
		return r;
	endfunction

	function automatic bit calm();
		return !idle_on || requests_todo.size() <= CALM_TAIL;
	endfunction

	task automatic queue_request(input logic [1:0] op, input logic [1:0] cls, input bit hold);
		request_t q;
		q.op   = op;
		q.cls  = cls;
		q.tag  = TAG_WIDTH'($urandom);
		q.hold = hold;
		requests_todo.push_back(q);
		requests_queued++;
	endtask

	// empty both rings, then space one class 0 and one class 1 item by a chosen stamp distance
	task automatic run_age_edge(input int spacing);
		repeat (QUEUE_DEPTH) queue_request(OP_DEQ0, 2'($urandom), 1'b0);
		repeat (QUEUE_DEPTH) queue_request(OP_DEQ1, 2'($urandom), 1'b0);
		queue_request(OP_ENQ, CLS_ZERO, 1'b0);
		repeat (spacing) queue_request(OP_ENQ, 2'($urandom_range(2, 3)), 1'b0);
		queue_request(OP_ENQ, CLS_ONE, 1'b0);
		repeat (3) queue_request(OP_DEQ_OLD, 2'($urandom), 1'b0);
	endtask

	task automatic run_mix(input bit hold);
		int len;
		int enq_pct;
		len     = $urandom_range(10, 40);
		enq_pct = $urandom_range(20, 80);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < enq_pct)
				queue_request(OP_ENQ, ($urandom_range(0, 15) == 0) ?
					2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1)), hold && i == 0);
			else
				queue_request(2'($urandom_range(1, 3)), 2'($urandom), hold && i == 0);
		end
	endtask

	// stimulus
	initial begin
		int edge_gaps [4];
		int edge_idx;
		int pick;
		edge_gaps = '{255, 127, 126, 128};
		edge_idx  = 0;

		// empty rings on every dequeue kind, then rejected classes
		queue_request(OP_DEQ0, CLS_ZERO, 1'b0);
		queue_request(OP_DEQ1, CLS_ONE, 1'b0);
		queue_request(OP_DEQ_OLD, 2'd3, 1'b0);
		queue_request(OP_ENQ, 2'd2, 1'b0);
		requests_todo[$].tag = '1;
		queue_request(OP_ENQ, 2'd3, 1'b0);
		requests_todo[$].tag = '0;
		queue_request(OP_ENQ, CLS_ZERO, 1'b0);
		requests_todo[$].tag = '0;
		// fill class 1 past its depth
		for (int i = 0; i <= QUEUE_DEPTH; i++) begin
			queue_request(OP_ENQ, CLS_ONE, 1'b0);
			if (i == 0)
				requests_todo[$].tag = '1;
		end
		queue_request(OP_DEQ_OLD, CLS_ZERO, 1'b0);
		queue_request(OP_DEQ_OLD, CLS_ZERO, 1'b0);

		// random part, the first sequence waits for the pipe to drain
		run_mix(1'b1);
		while (requests_queued < REQUEST_TARGET || edge_idx < 4) begin
			pick = $urandom_range(0, 9);
			if (pick == 0 && edge_idx < 4) begin
				run_age_edge(edge_gaps[edge_idx]);
				edge_idx++;
			end else if (pick == 1) begin
				pick = $urandom_range(0, 1);
				repeat (QUEUE_DEPTH + $urandom_range(1, 4))
					queue_request(OP_ENQ, pick[1:0], 1'b0);
			end else if (pick == 2) begin
				repeat (QUEUE_DEPTH + $urandom_range(1, 4))
					queue_request(2'($urandom_range(1, 3)), 2'($urandom), 1'b0);
			end else if (pick == 3) begin
				run_age_edge($urandom_range(0, 254));
			end else begin
				run_mix($urandom_range(0, 7) == 0);
			end
		end

		while (requests_todo.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// sample both channels; intake first so the new expectation lands behind older ones
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				results_due.push_back(predict_result(opcode, item_class, item_tag));
				req_done = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					log_mismatch("result transfer with no request outstanding");
				end else begin
					head_result = results_due.pop_front();
					if (status !== head_result.status)
						log_mismatch($sformatf("status %0d, want %0d", status, head_result.status));
					if (out_class !== head_result.cls)
						log_mismatch($sformatf("out_class %0d, want %0d", out_class,
							head_result.cls));
					if (out_tag !== head_result.tag)
						log_mismatch($sformatf("out_tag %h, want %h", out_tag, head_result.tag));
					if (out_stamp !== head_result.stamp)
						log_mismatch($sformatf("out_stamp %0d, want %0d", out_stamp,
							head_result.stamp));
				end
				results_seen++;
			end
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_done) begin
				req_done = 1'b0;
				sending  = 1'b0;
				void'(requests_todo.pop_front());
				if ($urandom_range(0, 63) == 0)
					idle_on = !idle_on;
				if (!calm() && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 15);
			end
			if (!sending) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (requests_todo.size() != 0 &&
						(!requests_todo[0].hold || results_due.size() == 0)) begin
					opcode     <= requests_todo[0].op;
					item_class <= requests_todo[0].cls;
					item_tag   <= requests_todo[0].tag;
					sending     = 1'b1;
				end
			end
			in_valid <= sending;
		end
	end

	// result sink with stall bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_stall > 0) begin
				sink_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm() && $urandom_range(0, 9) == 0)
					sink_stall = $urandom_range(1, 15);
			end
		end
	end

endmodule

@@ sim.f @@
rtl/tcf_pkg.sv
rtl/tcf_ram.sv
rtl/tcf_front.sv
rtl/tcf_back.sv
rtl/two_class_fifo_oldest_first.sv
tb/tb_two_class_fifo_oldest_first.sv
